@@ design/ese_pkg.sv @@
`default_nettype none
package ese_pkg;

  // default counter width and fixed-point format of the speed outputs
  localparam int COUNTER_BITS_DEF = 16;
  localparam int SPEED_FRAC_BITS  = 8;

  // 60 s/min * 1000 ms/s
  localparam int RPM_SCALE = 60000;

  // shared multiplier: signed 33 x signed 18
  localparam int MUL_A_W = 33;
  localparam int MUL_B_W = 18;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  // divider: 64-bit numerator, 48-bit denominator, 32-bit quotient
  localparam int NUM_W     = 64;
  localparam int DEN_W     = 48;
  localparam int QUOT_W    = 32;
  localparam int DIV_STEPS = QUOT_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  localparam int ALPHA_W = 17;
  localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'h10000;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_INTERVAL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNTS_REV   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA        = 2'd3;

  // register reset values
  localparam logic        ENABLE_RST       = 1'b1;
  localparam logic [15:0] MIN_INTERVAL_RST = 16'd10;
  localparam logic [15:0] COUNTS_REV_RST   = 16'd1000;
  localparam logic [ALPHA_W-1:0] ALPHA_RST = 17'd45875;

  typedef struct packed {
    logic done;
    logic overflow;
  } div_stat_t;

endpackage
`default_nettype wire

@@ design/ese_divider.sv @@
`default_nettype none
module ese_divider (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [ese_pkg::NUM_W-1:0]   num,
  input  wire logic [ese_pkg::DEN_W-1:0]   den,
  output      ese_pkg::div_stat_t          status,
  output      logic [ese_pkg::QUOT_W-1:0]  quotient
);

  logic                          busy;
  logic [ese_pkg::DIV_CNT_W-1:0] count;
  logic [ese_pkg::DEN_W-1:0]     rem;
  logic [ese_pkg::DEN_W-1:0]     divisor;
  logic [ese_pkg::QUOT_W-1:0]    quot;
  logic                          done;
  logic                          overflow;
  logic [ese_pkg::DEN_W:0]       trial;
  logic                          fits;

  // one restoring step: shift in the next dividend bit, subtract if it fits
  assign trial = {rem, quot[ese_pkg::QUOT_W-1]};
  assign fits  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= ese_pkg::DIV_CNT_W'(ese_pkg::DIV_STEPS);
      end else if (busy) begin
        count <= count - ese_pkg::DIV_CNT_W'(1);
        if (count == ese_pkg::DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      // quotient fits 32 bits only if the upper half is below the divisor
      rem      <= ese_pkg::DEN_W'(num[ese_pkg::NUM_W-1:ese_pkg::QUOT_W]);
      quot     <= num[ese_pkg::QUOT_W-1:0];
      divisor  <= den;
      overflow <= ese_pkg::DEN_W'(num[ese_pkg::NUM_W-1:ese_pkg::QUOT_W]) >= den;
    end else if (busy) begin
      if (fits) begin
        rem <= ese_pkg::DEN_W'(trial - {1'b0, divisor});
      end else begin
        rem <= trial[ese_pkg::DEN_W-1:0];
      end
      quot <= {quot[ese_pkg::QUOT_W-2:0], fits};
    end
  end

  assign status.done     = done;
  assign status.overflow = overflow;
  assign quotient        = quot;

endmodule
`default_nettype wire

@@ design/encoder_speed_estimator.sv @@
// encoder speed estimator
// sample channel: sample_valid / sample_stall with operation, counter_value and
// time_ms. operation 1 takes the sample as baseline and clears the position,
// operation 0 is an update that measures speed over the elapsed interval.
// result channel: result_valid / result_stall, one result per request.
// configuration: cfg_valid / cfg_ready write port, cfg_index selects enable,
// min_interval_ms, counts_per_rev or alpha_q16; cfg_ready is high outside reset.
// sequence: a start, a disabled update or an update that comes too early
// passes decode and finish; a speed update also passes the numerator and
// denominator products, the serial restoring divider that forms
// (count * 60000 << 8) / (dt * counts_per_rev), and both filter products.
// one shared 33x18 multiplier forms the numerator, the denominator and both
// filter products.
// the block takes one request at a time: sample_stall stays high from
// acceptance until the result is loaded into the output register.
// if the receiver stalls, the result register holds and a finished request
// waits until it can be loaded; the next request is accepted once it is.
// reset restores the register defaults and clears position, speed and baseline;
// sample_stall is high and cfg_ready low while rst is high.
`default_nettype none
module encoder_speed_estimator #(
  parameter int COUNTER_BITS = ese_pkg::COUNTER_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // sample channel
  input  wire logic                          sample_valid,
  output      logic                          sample_stall,
  input  wire logic                          operation,
  input  wire logic [COUNTER_BITS-1:0]       counter_value,
  input  wire logic [31:0]                   time_ms,
  // result channel
  output      logic                          result_valid,
  input  wire logic                          result_stall,
  output      logic                          updated,
  output      logic signed [31:0]            position_count,
  output      logic signed [31:0]            speed_rpm_q8,
  output      logic signed [31:0]            filtered_rpm_q8,
  // configuration
  input  wire logic                          cfg_valid,
  output      logic                          cfg_ready,
  input  wire logic [ese_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ese_pkg::ALPHA_W-1:0]   cfg_data
);

  localparam int DW = COUNTER_BITS + 2;
  localparam logic [DW-1:0] HALF = {2'b00, 1'b1, {(COUNTER_BITS-1){1'b0}}};
  localparam logic [DW-1:0] MODV = {2'b01, {COUNTER_BITS{1'b0}}};

  typedef enum logic [9:0] {
    S_IDLE     = 10'b0000000001,
    S_DECODE   = 10'b0000000010,
    S_MUL_NUM  = 10'b0000000100,
    S_MUL_DEN  = 10'b0000001000,
    S_DIV_GO   = 10'b0000010000,
    S_DIV_WAIT = 10'b0000100000,
    S_MUL_A    = 10'b0001000000,
    S_MUL_B    = 10'b0010000000,
    S_FILTER   = 10'b0100000000,
    S_FINISH   = 10'b1000000000
  } state_t;

  state_t state;
  state_t state_next;

  // configuration registers
  logic                        enable;
  logic [15:0]                 min_interval_ms;
  logic [15:0]                 counts_per_rev;
  logic [ese_pkg::ALPHA_W-1:0] alpha_q16;

  // architectural state
  logic [COUNTER_BITS-1:0] last_counter;
  logic [31:0]             last_time;
  logic [31:0]             position_acc;
  logic signed [31:0]      raw_speed;
  logic signed [31:0]      smooth_speed;

  // request and work registers
  logic                           op_q;
  logic [COUNTER_BITS-1:0]        cnt_q;
  logic [31:0]                    time_q;
  logic                           upd_q;
  logic [31:0]                    dt_q;
  logic [COUNTER_BITS-1:0]        mag_q;
  logic                           neg_q;
  logic [ese_pkg::NUM_W-1:0]      num_q;
  logic [ese_pkg::DEN_W-1:0]      den_q;
  logic signed [ese_pkg::PROD_W-1:0] acc_q;

  // combinational helpers
  logic                           accept;
  logic                           out_free;
  logic [31:0]                    dt;
  logic [15:0]                    min_eff;
  logic [15:0]                    cpr_eff;
  logic [ese_pkg::ALPHA_W-1:0]    alpha_eff;
  logic [ese_pkg::ALPHA_W-1:0]    beta;
  logic                           due;
  logic signed [DW-1:0]           diff;
  logic signed [DW-1:0]           delta;
  logic signed [DW-1:0]           delta_abs;
  logic signed [ese_pkg::MUL_A_W-1:0] mul_a;
  logic signed [ese_pkg::MUL_B_W-1:0] mul_b;
  logic signed [ese_pkg::PROD_W-1:0]  prod;
  logic                           div_start;
  ese_pkg::div_stat_t             div_status;
  logic [ese_pkg::QUOT_W-1:0]     quotient;
  logic signed [31:0]             rpm_sat;

  assign accept    = sample_valid && !sample_stall;
  assign sample_stall = rst || (state != S_IDLE);
  assign cfg_ready = !rst;
  assign out_free  = !result_valid || !result_stall;

  assign dt        = time_q - last_time;
  assign min_eff   = (min_interval_ms == 16'd0) ? 16'd1 : min_interval_ms;
  assign cpr_eff   = (counts_per_rev == 16'd0) ? 16'd1 : counts_per_rev;
  assign alpha_eff = (alpha_q16 > ese_pkg::ALPHA_ONE) ? ese_pkg::ALPHA_ONE : alpha_q16;
  assign beta      = ese_pkg::ALPHA_ONE - alpha_eff;
  assign due       = dt >= 32'(min_eff);

  // counter delta with wrap correction, half range stays positive
  always_comb begin
    diff = $signed(DW'(cnt_q)) - $signed(DW'(last_counter));
    if (diff > $signed(HALF)) begin
      delta = diff - $signed(MODV);
    end else if (diff < -$signed(HALF)) begin
      delta = diff + $signed(MODV);
    end else begin
      delta = diff;
    end
    delta_abs = delta[DW-1] ? -delta : delta;
  end

  // shared multiplier operand select
  always_comb begin
    unique case (state)
      S_MUL_NUM: begin
        mul_a = $signed(ese_pkg::MUL_A_W'(mag_q));
        mul_b = $signed(ese_pkg::MUL_B_W'(ese_pkg::RPM_SCALE));
      end
      S_MUL_DEN: begin
        mul_a = $signed({1'b0, dt_q});
        mul_b = $signed({2'b00, cpr_eff});
      end
      S_MUL_A: begin
        mul_a = ese_pkg::MUL_A_W'(raw_speed);
        mul_b = $signed({1'b0, alpha_eff});
      end
      S_MUL_B: begin
        mul_a = ese_pkg::MUL_A_W'(smooth_speed);
        mul_b = $signed({1'b0, beta});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  // truncate toward zero already done by the divider, now saturate and sign
  always_comb begin
    if (neg_q) begin
      if (div_status.overflow || quotient > 32'h8000_0000) begin
        rpm_sat = 32'sh8000_0000;
      end else begin
        rpm_sat = -$signed(quotient);
      end
    end else begin
      if (div_status.overflow || quotient[31]) begin
        rpm_sat = 32'sh7fff_ffff;
      end else begin
        rpm_sat = $signed(quotient);
      end
    end
  end

  assign div_start = (state == S_DIV_GO);

  ese_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .num      (num_q),
    .den      (den_q),
    .status   (div_status),
    .quotient (quotient)
  );

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:     if (accept) state_next = S_DECODE;
      S_DECODE: begin
        if (!op_q && enable && due) begin
          state_next = S_MUL_NUM;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_MUL_NUM:  state_next = S_MUL_DEN;
      S_MUL_DEN:  state_next = S_DIV_GO;
      S_DIV_GO:   state_next = S_DIV_WAIT;
      S_DIV_WAIT: if (div_status.done) state_next = S_MUL_A;
      S_MUL_A:    state_next = S_MUL_B;
      S_MUL_B:    state_next = S_FILTER;
      S_FILTER:   state_next = S_FINISH;
      S_FINISH:   if (out_free) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      enable          <= ese_pkg::ENABLE_RST;
      min_interval_ms <= ese_pkg::MIN_INTERVAL_RST;
      counts_per_rev  <= ese_pkg::COUNTS_REV_RST;
      alpha_q16       <= ese_pkg::ALPHA_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ese_pkg::CFG_ENABLE:       enable          <= cfg_data[0];
        ese_pkg::CFG_MIN_INTERVAL: min_interval_ms <= cfg_data[15:0];
        ese_pkg::CFG_COUNTS_REV:   counts_per_rev  <= cfg_data[15:0];
        ese_pkg::CFG_ALPHA:        alpha_q16       <= cfg_data;
        default: ;
      endcase
    end
  end

  // request capture and work registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q   <= operation;
      cnt_q  <= counter_value;
      time_q <= time_ms;
    end
    if (state == S_DECODE) begin
      dt_q  <= dt;
      mag_q <= delta_abs[COUNTER_BITS-1:0];
      neg_q <= delta[DW-1];
      upd_q <= op_q || (enable && due);
    end
    if (state == S_MUL_NUM) begin
      num_q <= ese_pkg::NUM_W'(prod[ese_pkg::DEN_W-1:0]) << ese_pkg::SPEED_FRAC_BITS;
    end
    if (state == S_MUL_DEN) begin
      den_q <= prod[ese_pkg::DEN_W-1:0];
    end
    if (state == S_MUL_A) begin
      acc_q <= prod + ese_pkg::PROD_W'(32768);
    end
    if (state == S_MUL_B) begin
      acc_q <= acc_q + prod;
    end
  end

  // architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      last_counter <= '0;
      last_time    <= '0;
      position_acc <= '0;
      raw_speed    <= '0;
      smooth_speed <= '0;
    end else begin
      if (state == S_DECODE) begin
        if (op_q) begin
          last_counter <= cnt_q;
          last_time    <= time_q;
          position_acc <= '0;
        end else if (enable && due) begin
          last_counter <= cnt_q;
          last_time    <= time_q;
          position_acc <= position_acc + 32'(delta);
        end
      end
      if (state == S_DIV_WAIT && div_status.done) begin
        raw_speed <= rpm_sat;
      end
      if (state == S_FILTER) begin
        // floor of the q16 sum, rounding constant already added
        smooth_speed <= acc_q[47:16];
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == S_FINISH && out_free) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FINISH && out_free) begin
      updated         <= upd_q;
      position_count  <= enable ? $signed(position_acc) : 32'sd0;
      speed_rpm_q8    <= enable ? raw_speed : 32'sd0;
      filtered_rpm_q8 <= enable ? smooth_speed : 32'sd0;
    end
  end

endmodule
`default_nettype wire
